[rtl/timed_step_sequencer_unit_defines.svh]
// Assertion macros shared by the timed step sequencer RTL.
// Included by modules that carry concurrent checks; needs clk and rst in scope.
`ifndef TIMED_STEP_SEQUENCER_UNIT_DEFINES_SVH
`define TIMED_STEP_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define TSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tss_pkg.sv]
// Shared constants, codes and types for the timed step sequencer.
// No dependencies; compiled before every other file.
package tss_pkg;

  localparam int MAX_STEPS   = 64;
  localparam int MIN_STEP_MS = 100;
  localparam int STEP_W      = $clog2(MAX_STEPS);
  localparam int COUNT_W     = 7;
  localparam int ELAPSED_W   = 17;
  localparam int DUR_W       = 16;
  localparam int DELTA_W     = 16;
  localparam int PROG_W      = 9;
  localparam int QUOT_W      = 8;
  localparam int DIV_CNT_W   = $clog2(QUOT_W);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [ELAPSED_W-1:0] elapsed_t;
  typedef logic [DUR_W-1:0]     dur_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam count_t MAX_STEPS_C = COUNT_W'(MAX_STEPS);
  localparam dur_t   MIN_STEP_C  = DUR_W'(MIN_STEP_MS);

  // operation codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_PLAY   = 3'd1;
  localparam logic [2:0] OP_PAUSE  = 3'd2;
  localparam logic [2:0] OP_TOGGLE = 3'd3;
  localparam logic [2:0] OP_RESET  = 3'd4;
  localparam logic [2:0] OP_NEXT   = 3'd5;
  localparam logic [2:0] OP_WRITE  = 3'd6;

  // run states
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_PLAYING  = 2'd1;
  localparam logic [1:0] MODE_PAUSED   = 2'd2;
  localparam logic [1:0] MODE_FINISHED = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t CFG_STEP_COUNT  = 2'd0;
  localparam cfg_idx_t CFG_LOOP_ENABLE = 2'd1;

  // duration table write port
  typedef struct packed {
    logic  en;
    step_t addr;
    dur_t  data;
  } tbl_wr_t;

  // shared compare/subtract result
  typedef struct packed {
    logic     ge;
    elapsed_t diff;
  } sub_res_t;

endpackage

[rtl/tss_if.sv]
// Valid/ready channel interfaces for command and result beats.
// Imports tss_pkg; the field widths are written out as literals.
interface tss_cmd_if;
  import tss_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [15:0] delta_ms;
  logic [5:0]         step_index;
  logic [15:0]        step_duration_ms;
  modport source (output valid, operation, delta_ms, step_index, step_duration_ms,
                  input ready);
  modport sink   (input valid, operation, delta_ms, step_index, step_duration_ms,
                  output ready);
endinterface

interface tss_res_if;
  import tss_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  run_state;
  logic [5:0]  step_now;
  logic [15:0] elapsed_now;
  logic [8:0]  progress;
  modport source (output valid, run_state, step_now, elapsed_now, progress,
                  input ready);
  modport sink   (input valid, run_state, step_now, elapsed_now, progress,
                  output ready);
endinterface

[rtl/timed_step_sequencer_unit.sv]
// Timed step sequencer: one result beat per command beat, one command at a time.
// From command beat to result beat: fetch, evaluate, 8 restoring divide steps, load; the
// divide is skipped when not needed, and a tick adds a fetch and evaluate per step it walks past.
// The next command is taken the cycle after the load; one waiting result is held while the
// next command runs, then load stalls.
// Reset (rst, synchronous): finished, step 0, elapsed 0, count 0, no loop, table zero.
module timed_step_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst,
  tss_cmd_if.sink                            cmd,
  tss_res_if.source                          res,
  input  logic                               cfg_we,
  input  tss_pkg::cfg_idx_t                  cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tss_pkg::*;
  `include "timed_step_sequencer_unit_defines.svh"

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EVAL, S_DIV, S_DONE} state_t;

  state_t            state;
  count_t            step_count;
  logic              loop_enable;
  logic [1:0]        mode;
  step_t             pos;
  elapsed_t          elapsed;
  logic              walking;
  dur_t              rem;
  logic [QUOT_W-2:0] quot;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PROG_W-1:0] prog;

  count_t            n_act;
  dur_t              rd_data;
  dur_t              len;
  elapsed_t          sub_a;
  sub_res_t          sub;
  tbl_wr_t           wr;
  logic              accept;
  elapsed_t          dt;
  logic [STEP_W:0]   adv;

  // one step forward: {finished, new position}
  function automatic logic [STEP_W:0] advance_pos(step_t p, count_t cnt, logic wrap);
    count_t          p1;
    logic [STEP_W:0] r;
    p1 = {1'b0, p} + COUNT_W'(1);
    if (p1 >= cnt) begin
      if (wrap) begin
        r = '0;
      end else begin
        r = {1'b1, STEP_W'(cnt - COUNT_W'(1))};
      end
    end else begin
      r = {1'b0, p1[STEP_W-1:0]};
    end
    return r;
  endfunction

  // effective count, step length, operand selection, tick delta, next step and table write
  always_comb begin
    n_act  = (step_count > MAX_STEPS_C) ? MAX_STEPS_C : step_count;
    len    = (rd_data < MIN_STEP_C) ? MIN_STEP_C : rd_data;
    sub_a  = (state == S_DIV) ? {rem, 1'b0} : elapsed;
    accept = cmd.valid && cmd.ready;
    dt     = cmd.delta_ms[DELTA_W-1] ? '0 : ELAPSED_W'(cmd.delta_ms[DELTA_W-2:0]);
    adv    = advance_pos(pos, n_act, loop_enable);
    wr.en   = accept && (cmd.operation == OP_WRITE)
              && (COUNT_W'(cmd.step_index) < MAX_STEPS_C);
    wr.addr = cmd.step_index;
    wr.data = cmd.step_duration_ms;
  end

  assign cmd.ready = (state == S_IDLE);

  tss_step_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (pos),
    .rdata (rd_data)
  );

  tss_sub u_sub (
    .a   (sub_a),
    .b   (len),
    .res (sub)
  );

  // sequencer, sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step_count  <= '0;
      loop_enable <= 1'b0;
      mode        <= MODE_FINISHED;
      pos         <= '0;
      elapsed     <= '0;
      walking     <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      // the load state handles its own hand-over of the result register
      if (res.valid && res.ready && state != S_DONE) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // configuration writes must arrive only while idle; the block ignores them otherwise
          if (cfg_we) begin
            if (cfg_index == CFG_STEP_COUNT) begin
              step_count <= cfg_data[COUNT_W-1:0];
              pos        <= '0;
              elapsed    <= '0;
              mode       <= (cfg_data[COUNT_W-1:0] != '0) ? MODE_IDLE : MODE_FINISHED;
            end else if (cfg_index == CFG_LOOP_ENABLE) begin
              loop_enable <= cfg_data[0];
            end
          end
          if (accept) begin
            state   <= S_FETCH;
            walking <= 1'b0;
            case (cmd.operation)
              OP_TICK: begin
                if (mode == MODE_PLAYING) begin
                  if (n_act == '0) begin
                    mode <= MODE_FINISHED;
                  end else begin
                    elapsed <= elapsed + dt;
                    walking <= 1'b1;
                  end
                end
              end
              OP_PLAY, OP_TOGGLE: begin
                if (cmd.operation == OP_TOGGLE && mode == MODE_PLAYING) begin
                  mode <= MODE_PAUSED;
                end else if (n_act != '0) begin
                  if (mode == MODE_FINISHED) begin
                    pos     <= '0;
                    elapsed <= '0;
                  end
                  mode <= MODE_PLAYING;
                end
              end
              OP_PAUSE: begin
                if (mode == MODE_PLAYING) begin
                  mode <= MODE_PAUSED;
                end
              end
              OP_RESET: begin
                pos     <= '0;
                elapsed <= '0;
                mode    <= (n_act != '0) ? MODE_IDLE : MODE_FINISHED;
              end
              OP_NEXT: begin
                if (n_act != '0) begin
                  pos     <= adv[STEP_W-1:0];
                  elapsed <= '0;
                  if (adv[STEP_W]) begin
                    mode <= MODE_FINISHED;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        // table read of the current step is in flight
        S_FETCH: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (n_act == '0) begin
            prog  <= '0;
            state <= S_DONE;
          end else if (walking && sub.ge) begin
            // step covered: move on and fetch the next length
            state <= S_FETCH;
            pos   <= adv[STEP_W-1:0];
            if (adv[STEP_W]) begin
              mode    <= MODE_FINISHED;
              elapsed <= '0;
              walking <= 1'b0;
            end else begin
              elapsed <= sub.diff;
            end
          end else if (sub.ge) begin
            prog  <= PROG_W'(1 << QUOT_W);
            state <= S_DONE;
          end else begin
            rem     <= elapsed[DUR_W-1:0];
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          quot    <= {quot[QUOT_W-3:0], sub.ge};
          rem     <= sub.ge ? sub.diff[DUR_W-1:0] : sub_a[DUR_W-1:0];
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(QUOT_W - 1)) begin
            prog  <= {1'b0, quot, sub.ge};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.run_state   <= mode;
            res.step_now    <= pos;
            res.elapsed_now <= elapsed[ELAPSED_W-1] ? '1 : elapsed[DUR_W-1:0];
            res.progress    <= prog;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `TSS_ASSERT_NEXT(a_busy_after_beat, cmd.valid && cmd.ready, !cmd.ready,
                   "command accepted while a previous one is in work")
  `TSS_ASSERT_NOW(a_div_rem_below_len, state == S_DIV, rem < len,
                  "divider remainder not below step length")
  `TSS_ASSERT_NOW(a_pos_in_range, state == S_IDLE && n_act != '0, COUNT_W'(pos) < n_act,
                  "step position beyond programmed count")
  `TSS_ASSERT_NOW(a_elapsed_bounded, state == S_IDLE, elapsed < ELAPSED_W'(17'h0FFFF),
                  "stored elapsed time out of range between commands")
  `TSS_ASSERT_NOW(a_result_from_done, $rose(res.valid), $past(state == S_DONE),
                  "result beat raised outside the load state")

endmodule

[rtl/tss_step_mem.sv]
// Step duration table: one write port, one registered read port.
// Per-entry valid flags make unwritten entries read as zero after reset.
module tss_step_mem (
  input  logic             clk,
  input  logic             rst,
  input  tss_pkg::tbl_wr_t wr,
  input  tss_pkg::step_t   raddr,
  output tss_pkg::dur_t    rdata
);
  import tss_pkg::*;

  dur_t                 mem [MAX_STEPS];
  logic [MAX_STEPS-1:0] valid;

  // storage write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // registered read, zero for entries never written
  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

[rtl/tss_sub.sv]
// Shared compare and subtract unit, used for step walking and division.
// Depends on tss_pkg for its port types and the result struct.
module tss_sub (
  input  tss_pkg::elapsed_t a,
  input  tss_pkg::dur_t     b,
  output tss_pkg::sub_res_t res
);
  import tss_pkg::*;

  logic [ELAPSED_W:0] d;

  // one extra bit gives the borrow
  always_comb begin
    d        = {1'b0, a} - {2'b00, b};
    res.ge   = ~d[ELAPSED_W];
    res.diff = d[ELAPSED_W-1:0];
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for timed_step_sequencer_unit: directed and random command beats,
// with a transaction-level state tracker predicting every status beat.
// Depends on tss_pkg and the tss_cmd_if / tss_res_if channel interfaces.
module tb_top;
  import tss_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned END_CYCLES    = 100;
  localparam int unsigned HOLD_AT       = 200;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 75;

  // code with no operation behind it, and register slots that hold nothing
  localparam logic [2:0] OP_NONE     = 3'd7;
  localparam cfg_idx_t   CFG_SPARE_2 = 2'd2;
  localparam cfg_idx_t   CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [1:0]  run_state;
    logic [5:0]  step_now;
    logic [15:0] elapsed_now;
    logic [8:0]  progress;
  } seq_status_t;

  // Tracks sequencer state and holds the status beats still owed by the block
  class step_tracker;
    logic [6:0]  count_reg;
    bit          loop_reg;
    logic [1:0]  mode;
    int unsigned pos;
    int unsigned elapsed;
    logic [15:0] dur_ms [MAX_STEPS];
    seq_status_t pending [$];
    int          errors;

    function new();
      count_reg = '0;
      loop_reg  = 1'b0;
      errors    = 0;
      foreach (dur_ms[i]) dur_ms[i] = '0;
      restart();
    endfunction

    function int unsigned active();
      return (count_reg > MAX_STEPS) ? MAX_STEPS : count_reg;
    endfunction

    function int unsigned step_len(int unsigned p);
      return (dur_ms[p] < MIN_STEP_MS) ? MIN_STEP_MS : dur_ms[p];
    endfunction

    function void restart();
      pos     = 0;
      elapsed = 0;
      mode    = (active() != 0) ? MODE_IDLE : MODE_FINISHED;
    endfunction

    function void start_play();
      if (active() == 0) return;
      if (mode == MODE_FINISHED) begin
        pos     = 0;
        elapsed = 0;
      end
      mode = MODE_PLAYING;
    endfunction

    // one step forward; returns 1 when the sequence has just finished
    function bit advance();
      int unsigned n;
      n = active();
      pos++;
      if (pos >= n) begin
        if (loop_reg) begin
          pos = 0;
        end else begin
          pos  = n - 1;
          mode = MODE_FINISHED;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void tick(logic signed [15:0] delta);
      if (mode != MODE_PLAYING) return;
      if (active() == 0) begin
        mode = MODE_FINISHED;
        return;
      end
      elapsed += delta[15] ? 0 : delta[14:0];
      // walk every step the tick covers; finishing clears the elapsed time
      while (elapsed >= step_len(pos)) begin
        elapsed -= step_len(pos);
        if (advance()) elapsed = 0;
      end
      elapsed &= 32'h1FFFF;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_STEP_COUNT: begin
          count_reg = data;
          restart();
        end
        CFG_LOOP_ENABLE: loop_reg = data[0];
        default: ;
      endcase
    endfunction

    function void accept_cmd(logic [2:0] op, logic signed [15:0] delta, logic [5:0] idx,
                             logic [15:0] dur);
      seq_status_t     want;
      longint unsigned q;
      case (op)
        OP_TICK:   tick(delta);
        OP_PLAY:   start_play();
        OP_PAUSE:  if (mode == MODE_PLAYING) mode = MODE_PAUSED;
        OP_TOGGLE: begin
          if (mode == MODE_PLAYING) mode = MODE_PAUSED;
          else start_play();
        end
        OP_RESET:  restart();
        OP_NEXT: begin
          if (active() != 0) begin
            void'(advance());
            elapsed = 0;
          end
        end
        // a 6-bit index always lands inside the table
        OP_WRITE:  dur_ms[idx] = dur;
        default: ;
      endcase
      q = 0;
      if (active() != 0) begin
        q = (longint'(elapsed) << 8) / step_len(pos);
        if (q > 256) q = 256;
      end
      want.run_state   = mode;
      want.step_now    = pos[5:0];
      want.elapsed_now = (elapsed > 32'hFFFF) ? 16'hFFFF : elapsed[15:0];
      want.progress    = q[8:0];
      pending.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want_v, logic [15:0] got_v);
      if (got_v !== 16'(want_v)) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      end
    endfunction

    function void check_status(seq_status_t got);
      seq_status_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: status beat with nothing expected, expected none, got %p", $time, got);
        return;
      end
      want = pending.pop_front();
      compare_field("run_state", want.run_state, 16'(got.run_state));
      compare_field("step_now", want.step_now, 16'(got.step_now));
      compare_field("elapsed_now", want.elapsed_now, got.elapsed_now);
      compare_field("progress", want.progress, 16'(got.progress));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           send_gap_max;
  int unsigned           cycles;
  step_tracker           tracker = new();

  tss_cmd_if cmd_ch ();
  tss_res_if res_ch ();

  timed_step_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one command beat after a random gap; returns at the falling edge after acceptance
  task automatic send_cmd(input logic [2:0] op, input logic signed [15:0] delta,
                          input logic [5:0] idx, input logic [15:0] dur);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid            <= 1'b1;
    cmd_ch.operation        <= op;
    cmd_ch.delta_ms         <= delta;
    cmd_ch.step_index       <= idx;
    cmd_ch.step_duration_ms <= dur;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    tracker.accept_cmd(op, delta, idx, dur);
    @(negedge clk);
  endtask

  // Stop offering and wait for every owed status beat, then let the block settle
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    tracker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Programme the leading steps, start playing, then a weighted mix of commands
  task automatic random_phase(input int unsigned n_items);
    int unsigned       span;
    int unsigned       r;
    int unsigned       r2;
    logic [2:0]        op;
    logic signed [15:0] delta;
    logic [5:0]        idx;
    logic [15:0]       dur;
    span = tracker.active();
    for (int i = 0; i < span && i < 6; i++)
      send_cmd(OP_WRITE, 16'($urandom), 6'(i), 16'($urandom_range(0, 400)));
    send_cmd(OP_PLAY, 16'($urandom), 6'($urandom), 16'($urandom));
    repeat (n_items) begin
      r2 = $urandom_range(0, 99);
      if (r2 < 60)      delta = 16'($urandom_range(0, 250));
      else if (r2 < 75) delta = 16'(16'h8000 | $urandom_range(0, 16'h7FFF));
      else if (r2 < 90) delta = 16'($urandom_range(250, 2000));
      else              delta = 16'($urandom_range(0, 65535));
      r2 = $urandom_range(0, 99);
      if (r2 < 60)      dur = 16'($urandom_range(0, 300));
      else if (r2 < 85) dur = 16'($urandom_range(300, 3000));
      else              dur = 16'($urandom_range(0, 65535));
      if (span != 0 && $urandom_range(0, 1) == 1) idx = 6'($urandom_range(0, span - 1));
      else idx = 6'($urandom_range(0, 63));
      r = $urandom_range(0, 99);
      if (r < 45)      op = OP_TICK;
      else if (r < 58) op = OP_WRITE;
      else if (r < 66) op = OP_PLAY;
      else if (r < 71) op = OP_PAUSE;
      else if (r < 77) op = OP_TOGGLE;
      else if (r < 80) op = OP_RESET;
      else if (r < 88) op = OP_NEXT;
      else if (r < 91) op = OP_NONE;
      else             op = OP_TICK;
      send_cmd(op, delta, idx, dur);
    end
  endtask

  // Status sink: random back-pressure, quiet stretches, and one long hold-off
  initial begin : status_sink
    int unsigned wait_n;
    int unsigned taken;
    bit          quiet;
    seq_status_t got;
    res_ch.ready <= 1'b0;
    taken = 0;
    quiet = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        wait_n = quiet ? 0 : $urandom_range(0, 12);
        if (wait_n != 0) begin
          res_ch.ready <= 1'b0;
          repeat (wait_n) @(negedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      got.run_state   = res_ch.run_state;
      got.step_now    = res_ch.step_now;
      got.elapsed_now = res_ch.elapsed_now;
      got.progress    = res_ch.progress;
      tracker.check_status(got);
      taken++;
      if (taken % 30 == 0) quiet = !quiet;
      @(negedge clk);
    end
  end

  // Main sequence
  initial begin : command_source
    logic [6:0] count_sel;
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_STEP_COUNT;
    cfg_data                <= '0;
    cmd_ch.valid            <= 1'b0;
    cmd_ch.operation        <= OP_TICK;
    cmd_ch.delta_ms         <= '0;
    cmd_ch.step_index       <= '0;
    cmd_ch.step_duration_ms <= '0;
    send_gap_max = 12;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty sequence: commands must leave the finished state alone
    cfg_write(CFG_STEP_COUNT, 7'd0);
    cfg_write(CFG_LOOP_ENABLE, 7'd0);
    send_cmd(OP_TICK, 16'sd100, 6'd0, 16'd0);
    send_cmd(OP_PLAY, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_TOGGLE, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_NEXT, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_NONE, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_WRITE, 16'sd0, 6'd63, 16'hFFFF);
    send_cmd(OP_WRITE, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_WRITE, 16'sd0, 6'd1, 16'd50);
    send_cmd(OP_WRITE, 16'sd0, 6'd2, 16'd250);
    send_cmd(OP_WRITE, 16'sd0, 6'd3, 16'd1000);
    drain();

    // four steps, no loop: minimum duration, negative ticks, pause/toggle, finish
    cfg_write(CFG_STEP_COUNT, 7'd4);
    send_cmd(OP_TICK, 16'sd500, 6'd0, 16'd0);
    send_cmd(OP_PLAY, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_TICK, 16'sd99, 6'd0, 16'd0);
    send_cmd(OP_TICK, -16'sd32768, 6'd0, 16'd0);
    send_cmd(OP_TICK, 16'sd176, 6'd0, 16'd0);
    send_cmd(OP_PAUSE, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_TICK, 16'sd300, 6'd0, 16'd0);
    send_cmd(OP_PAUSE, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_TOGGLE, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_TICK, 16'sd32767, 6'd0, 16'd0);
    send_cmd(OP_PLAY, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_TOGGLE, 16'sd0, 6'd0, 16'd0);
    repeat (4) send_cmd(OP_NEXT, 16'sd0, 6'd0, 16'd0);
    send_cmd(OP_RESET, 16'sd0, 6'd0, 16'd0);
    drain();

    // count above the table size with looping: long walks and wrap by tick and by next
    cfg_write(CFG_STEP_COUNT, 7'd127);
    cfg_write(CFG_LOOP_ENABLE, 7'h7F);
    send_cmd(OP_PLAY, 16'sd0, 6'd0, 16'd0);
    repeat (3) send_cmd(OP_TICK, 16'sd32767, 6'd0, 16'd0);
    send_cmd(OP_WRITE, 16'sd0, 6'd0, 16'd120);
    repeat (2) send_cmd(OP_NEXT, 16'sd0, 6'd0, 16'd0);
    drain();

    // random phases across several settings
    for (int p = 0; p < 6; p++) begin
      send_gap_max = (p % 3 == 2) ? 0 : 12;
      case (p)
        0: count_sel = 7'd64;
        1: count_sel = 7'd1;
        default: begin
          case ($urandom_range(0, 4))
            0: count_sel = 7'd2;
            1: count_sel = 7'($urandom_range(65, 127));
            2: count_sel = 7'd0;
            default: count_sel = 7'($urandom_range(3, 12));
          endcase
        end
      endcase
      cfg_write(CFG_STEP_COUNT, count_sel);
      cfg_write(CFG_LOOP_ENABLE, {6'($urandom), 1'(p % 2)});
      cfg_write((p % 2 == 1) ? CFG_SPARE_3 : CFG_SPARE_2, 7'($urandom));
      random_phase(PHASE_ITEMS);
      drain();
    end

    repeat (END_CYCLES) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[timed_step_sequencer_unit.f]
+incdir+rtl
rtl/tss_pkg.sv
rtl/tss_if.sv
rtl/tss_step_mem.sv
rtl/tss_sub.sv
rtl/timed_step_sequencer_unit.sv
dv/tb_top.sv
